FILE: rtl/core/bdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared codes, widths and controller/datapath interface types of the
// bounded deque unit.
// ----------------------------------------------------------------------------
package bdq_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int OP_W    = 3;
   localparam int VALUE_W = 32;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 5;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   localparam logic [OP_W-1:0] OP_ADD_HEAD    = 3'd0;
   localparam logic [OP_W-1:0] OP_ADD_TAIL    = 3'd1;
   localparam logic [OP_W-1:0] OP_REMOVE_HEAD = 3'd2;
   localparam logic [OP_W-1:0] OP_REMOVE_TAIL = 3'd3;
   localparam logic [OP_W-1:0] OP_SEARCH      = 3'd4;
   localparam logic [OP_W-1:0] OP_DEDUP       = 3'd5;
   localparam logic [OP_W-1:0] OP_READ_OUT    = 3'd6;

   localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic              latch_req;
      logic              clr_idx;
      logic              push_head;
      logic              push_tail;
      logic              pop_head;
      logic              pop_tail;
      logic              rd_i;
      logic              rd_j;
      logic              clr_j;
      logic              inc_i;
      logic              inc_j;
      logic              latch_rd_val;
      logic              keep;
      logic              set_found;
      logic              commit_kept;
      logic              load_rsp;
      logic [STAT_W-1:0] rsp_status;
      logic              rsp_elem_sel;
      logic              rsp_last;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            full;
      logic            empty;
      logic            i_last;
      logic            i_end;
      logic            j_end;
      logic            match;
      logic            out_free;
   } stat_type;

endpackage

FILE: rtl/core/bdq_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_dpath
// Circular element store, head/count registers, walk counters and the
// registered result stage.
// ----------------------------------------------------------------------------
module bdq_dpath #(
   parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bdq_pkg::cmd_type                  cmd,
   output bdq_pkg::stat_type                 stat,
   input  logic [bdq_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bdq_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tlast
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [bdq_pkg::VALUE_W-1:0] store_ff [DEPTH];
   logic [bdq_pkg::VALUE_W-1:0] rd_data_ff;

   logic [bdq_pkg::OP_W-1:0]    op_ff, op_in;
   logic [bdq_pkg::VALUE_W-1:0] val_ff, val_in;
   logic [AW-1:0]               front_ff, front_in;
   logic [CW-1:0]               occ_ff, occ_in;
   logic [CW-1:0]               i_ff, i_in;
   logic [CW-1:0]               j_ff, j_in;
   logic [CW-1:0]               kept_ff, kept_in;
   logic                        found_ff, found_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [bdq_pkg::STAT_W-1:0]    rsp_status_ff, rsp_status_in;
   logic                          rsp_found_ff, rsp_found_in;
   logic [bdq_pkg::COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic [bdq_pkg::VALUE_W-1:0]   rsp_elem_ff, rsp_elem_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic [AW-1:0]               front_dec, front_inc;
   logic                        wr_en;
   logic [AW-1:0]               wr_addr;
   logic [bdq_pkg::VALUE_W-1:0] wr_data;
   logic                        rd_en;
   logic [AW-1:0]               rd_addr;
   logic [CW+4:0]               occ_ext;

   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] front,
                                             input logic [CW-1:0] rel);
      logic [CW:0] sum;
      sum = (CW+1)'(front) + (CW+1)'(rel);
      if (sum >= (CW+1)'(DEPTH)) begin
         sum = sum - (CW+1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   assign front_dec = (front_ff == '0) ? AW'(DEPTH - 1) : front_ff - AW'(1);
   assign front_inc = (front_ff == AW'(DEPTH - 1)) ? '0 : front_ff + AW'(1);

   // write port
   always_comb begin
      wr_en   = cmd.push_head | cmd.push_tail | cmd.keep;
      wr_data = val_ff;
      if (cmd.push_head) begin
         wr_addr = front_dec;
      end else if (cmd.push_tail) begin
         wr_addr = slot_of(front_ff, occ_ff);
      end else begin
         wr_addr = slot_of(front_ff, kept_ff);
      end
   end

   // read port
   assign rd_en   = cmd.rd_i | cmd.rd_j;
   assign rd_addr = cmd.rd_j ? slot_of(front_ff, j_ff) : slot_of(front_ff, i_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   always_comb begin
      op_in    = op_ff;
      val_in   = val_ff;
      front_in = front_ff;
      occ_in   = occ_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      kept_in  = kept_ff;
      found_in = found_ff;

      if (cmd.latch_req) begin
         op_in  = req_tdata[bdq_pkg::OP_W-1:0];
         val_in = req_tdata[bdq_pkg::OP_W+bdq_pkg::VALUE_W-1:bdq_pkg::OP_W];
      end else if (cmd.latch_rd_val) begin
         val_in = rd_data_ff;
      end

      if (cmd.push_head) begin
         front_in = front_dec;
         occ_in   = occ_ff + CW'(1);
      end else if (cmd.push_tail) begin
         occ_in   = occ_ff + CW'(1);
      end else if (cmd.pop_head) begin
         front_in = front_inc;
         occ_in   = occ_ff - CW'(1);
      end else if (cmd.pop_tail) begin
         occ_in   = occ_ff - CW'(1);
      end else if (cmd.commit_kept) begin
         occ_in   = kept_ff;
      end

      if (cmd.clr_idx) begin
         i_in     = '0;
         j_in     = '0;
         kept_in  = '0;
         found_in = 1'b0;
      end else begin
         if (cmd.inc_i) begin
            i_in = i_ff + CW'(1);
         end
         if (cmd.clr_j) begin
            j_in = '0;
         end else if (cmd.inc_j) begin
            j_in = j_ff + CW'(1);
         end
         if (cmd.keep) begin
            kept_in = kept_ff + CW'(1);
         end
         if (cmd.set_found) begin
            found_in = 1'b1;
         end
      end
   end

   // result stage
   assign occ_ext = {5'b0, occ_ff};

   always_comb begin
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_elem_in   = rsp_elem_ff;
      rsp_last_in   = rsp_last_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = cmd.rsp_status;
         rsp_found_in  = found_ff;
         rsp_count_in  = occ_ext[bdq_pkg::COUNT_W-1:0];
         rsp_elem_in   = cmd.rsp_elem_sel ? rd_data_ff : '0;
         rsp_last_in   = cmd.rsp_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         occ_ff       <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         kept_ff      <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         occ_ff       <= occ_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         kept_ff      <= kept_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      val_ff        <= val_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_elem_ff   <= rsp_elem_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      stat.op       = op_ff;
      stat.full     = (occ_ff == CW'(DEPTH));
      stat.empty    = (occ_ff == '0);
      stat.i_last   = (i_ff + CW'(1) == occ_ff);
      stat.i_end    = (i_ff == occ_ff);
      stat.j_end    = (j_ff == kept_ff);
      stat.match    = (rd_data_ff == val_ff);
      stat.out_free = ~rsp_valid_ff | rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {rsp_elem_ff, rsp_count_ff, rsp_found_ff, rsp_status_ff};

endmodule

FILE: rtl/core/bdq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_ctrl
// Sequencer: decodes one request at a time and steps the datapath through
// the search, read out and duplicate removal walks.
// ----------------------------------------------------------------------------
module bdq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  bdq_pkg::stat_type stat,
   output bdq_pkg::cmd_type  cmd
);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_DECODE   = 4'd1;
   localparam logic [3:0] ST_RESULT   = 4'd2;
   localparam logic [3:0] ST_SRCH_RD  = 4'd3;
   localparam logic [3:0] ST_SRCH_CMP = 4'd4;
   localparam logic [3:0] ST_RD_ISSUE = 4'd5;
   localparam logic [3:0] ST_RD_EMIT  = 4'd6;
   localparam logic [3:0] ST_DD_RD_I  = 4'd7;
   localparam logic [3:0] ST_DD_LATCH = 4'd8;
   localparam logic [3:0] ST_DD_CHK   = 4'd9;
   localparam logic [3:0] ST_DD_CMP   = 4'd10;

   logic [3:0]                 state_ff, state_in;
   logic [bdq_pkg::STAT_W-1:0] status_ff, status_in;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      status_in  = status_ff;
      req_tready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_DECODE;
            end
         end

         ST_DECODE: begin
            cmd.clr_idx = 1'b1;
            status_in   = bdq_pkg::STATUS_OK;
            state_in    = ST_RESULT;
            case (stat.op)
               bdq_pkg::OP_ADD_HEAD, bdq_pkg::OP_ADD_TAIL: begin
                  if (stat.full) begin
                     status_in = bdq_pkg::STATUS_FULL;
                  end else if (stat.op == bdq_pkg::OP_ADD_HEAD) begin
                     cmd.push_head = 1'b1;
                  end else begin
                     cmd.push_tail = 1'b1;
                  end
               end
               bdq_pkg::OP_REMOVE_HEAD, bdq_pkg::OP_REMOVE_TAIL: begin
                  if (stat.empty) begin
                     status_in = bdq_pkg::STATUS_EMPTY;
                  end else if (stat.op == bdq_pkg::OP_REMOVE_HEAD) begin
                     cmd.pop_head = 1'b1;
                  end else begin
                     cmd.pop_tail = 1'b1;
                  end
               end
               bdq_pkg::OP_SEARCH: begin
                  if (stat.empty) begin
                     status_in = bdq_pkg::STATUS_EMPTY;
                  end else begin
                     state_in = ST_SRCH_RD;
                  end
               end
               bdq_pkg::OP_DEDUP: begin
                  if (stat.empty) begin
                     status_in = bdq_pkg::STATUS_EMPTY;
                  end else begin
                     state_in = ST_DD_RD_I;
                  end
               end
               bdq_pkg::OP_READ_OUT: begin
                  if (stat.empty) begin
                     status_in = bdq_pkg::STATUS_EMPTY;
                  end else begin
                     state_in = ST_RD_ISSUE;
                  end
               end
               default: begin
               end
            endcase
         end

         ST_RESULT: begin
            if (stat.out_free) begin
               cmd.load_rsp   = 1'b1;
               cmd.rsp_status = status_ff;
               cmd.rsp_last   = 1'b1;
               state_in       = ST_IDLE;
            end
         end

         ST_SRCH_RD: begin
            cmd.rd_i = 1'b1;
            state_in = ST_SRCH_CMP;
         end

         ST_SRCH_CMP: begin
            if (stat.match) begin
               cmd.set_found = 1'b1;
               state_in      = ST_RESULT;
            end else if (stat.i_last) begin
               state_in = ST_RESULT;
            end else begin
               cmd.inc_i = 1'b1;
               state_in  = ST_SRCH_RD;
            end
         end

         ST_RD_ISSUE: begin
            cmd.rd_i = 1'b1;
            state_in = ST_RD_EMIT;
         end

         ST_RD_EMIT: begin
            if (stat.out_free) begin
               cmd.load_rsp     = 1'b1;
               cmd.rsp_status   = bdq_pkg::STATUS_OK;
               cmd.rsp_elem_sel = 1'b1;
               cmd.rsp_last     = stat.i_last;
               cmd.inc_i        = 1'b1;
               state_in         = stat.i_last ? ST_IDLE : ST_RD_ISSUE;
            end
         end

         // outer walk: next candidate, or commit the compacted count
         ST_DD_RD_I: begin
            if (stat.i_end) begin
               cmd.commit_kept = 1'b1;
               state_in        = ST_RESULT;
            end else begin
               cmd.rd_i  = 1'b1;
               cmd.clr_j = 1'b1;
               state_in  = ST_DD_LATCH;
            end
         end

         ST_DD_LATCH: begin
            cmd.latch_rd_val = 1'b1;
            state_in         = ST_DD_CHK;
         end

         // inner walk over survivors kept so far
         ST_DD_CHK: begin
            if (stat.j_end) begin
               cmd.keep  = 1'b1;
               cmd.inc_i = 1'b1;
               state_in  = ST_DD_RD_I;
            end else begin
               cmd.rd_j = 1'b1;
               state_in = ST_DD_CMP;
            end
         end

         ST_DD_CMP: begin
            if (stat.match) begin
               cmd.inc_i = 1'b1;
               state_in  = ST_DD_RD_I;
            end else begin
               cmd.inc_j = 1'b1;
               state_in  = ST_DD_CHK;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         status_ff <= bdq_pkg::STATUS_OK;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

endmodule

FILE: rtl/core/bounded_deque_with_search_dedup_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_search_dedup_unit
// Bounded double-ended queue of signed 32-bit values with search, in-order
// duplicate removal and read out. One request is worked on at a time.
// The next request is taken while the last result waits in the output
// register. Reset clears head position and count; the store itself is
// not cleared.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_dedup_unit #(
   parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // operation[2:0], item_value[34:3], zero pad[39:35]
   input  logic [bdq_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // status[1:0], found[2], entry_count[7:3], element[39:8]
   output logic [bdq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast
);

   bdq_pkg::cmd_type  cmd;
   bdq_pkg::stat_type stat;

   bdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   bdq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous one still in progress");

   a_no_result_overrun: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> stat.out_free)
      else $error("result loaded over one not yet taken");

   a_count_consistent: assert property (@(posedge clock) disable iff (reset)
      !(stat.full && stat.empty))
      else $error("store reported both full and empty");

   a_single_store_access: assert property (@(posedge clock) disable iff (reset)
      !(cmd.rd_i && cmd.rd_j) && !(cmd.push_head && cmd.push_tail))
      else $error("conflicting store commands");

endmodule

FILE: test/bounded_deque_with_search_dedup_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_search_dedup_unit_tb
// Self-checking bench for the bounded deque unit. The bench keeps its own
// shadow deque of the stored values. Each accepted request updates that
// shadow copy and queues the results due. The monitor compares every
// accepted result with the oldest result due, field by field. The first
// part is directed: the empty store, the value extremes, duplicates and
// the unused operation code. A pressure phase fills the store to full
// while the result side is held off for a long stretch. Random traffic
// then runs under three pacing modes.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_dedup_unit_tb;
   import bdq_pkg::*;

   localparam int DEPTH            = DEPTH_DEFAULT;
   localparam int RESET_CYCLES     = 12;
   localparam int RSP_HOLD_CYCLES  = 400;
   localparam int STALL_LIMIT      = 5000;
   localparam int TAIL_CYCLES      = 50;
   localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [VALUE_W-1:0] value;
   } deque_req_t;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic               found;
      logic [COUNT_W-1:0] count;
      logic [VALUE_W-1:0] element;
      logic               last;
   } deque_rsp_t;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   deque_req_t pending_ops[$];
   deque_rsp_t results_due[$];
   deque_req_t req_held;

   logic [VALUE_W-1:0] shadow_store[DEPTH];
   int unsigned        shadow_front = 0;
   int unsigned        shadow_count = 0;

   int          req_idle_pct = 0;
   int          rsp_idle_pct = 0;
   logic        hold_go      = 1'b0;
   logic        hold_done    = 1'b0;
   int unsigned hold_left    = 0;
   int unsigned stall_cycles = 0;
   int unsigned error_count  = 0;

   bounded_deque_with_search_dedup_unit #(.DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow deque: applies one request, queues the results it causes
   task automatic predict_deque_op(input deque_req_t req);
      deque_rsp_t         r;
      logic [VALUE_W-1:0] v;
      int unsigned        kept;
      logic               seen;
      r      = '0;
      r.last = 1'b1;
      case (req.op)
         OP_ADD_HEAD, OP_ADD_TAIL: begin
            if (shadow_count >= DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               if (req.op == OP_ADD_HEAD) begin
                  shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
                  shadow_store[shadow_front] = req.value;
               end else begin
                  shadow_store[(shadow_front + shadow_count) % DEPTH] = req.value;
               end
               shadow_count++;
            end
         end
         OP_REMOVE_HEAD, OP_REMOVE_TAIL: begin
            if (shadow_count == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               if (req.op == OP_REMOVE_HEAD)
                  shadow_front = (shadow_front + 1) % DEPTH;
               shadow_count--;
            end
         end
         OP_SEARCH: begin
            if (shadow_count == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               for (int i = 0; i < shadow_count; i++)
                  if (shadow_store[(shadow_front + i) % DEPTH] == req.value)
                     r.found = 1'b1;
            end
         end
         OP_DEDUP: begin
            if (shadow_count == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               kept = 0;
               for (int i = 0; i < shadow_count; i++) begin
                  v    = shadow_store[(shadow_front + i) % DEPTH];
                  seen = 1'b0;
                  for (int j = 0; j < kept; j++)
                     if (shadow_store[(shadow_front + j) % DEPTH] == v)
                        seen = 1'b1;
                  if (!seen) begin
                     shadow_store[(shadow_front + kept) % DEPTH] = v;
                     kept++;
                  end
               end
               shadow_count = kept;
            end
         end
         OP_READ_OUT: begin
            if (shadow_count == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               r.count = COUNT_W'(shadow_count);
               for (int i = 0; i < shadow_count; i++) begin
                  r.element = shadow_store[(shadow_front + i) % DEPTH];
                  r.last    = (i + 1 == shadow_count);
                  results_due.push_back(r);
               end
               return;
            end
         end
         default: ;
      endcase
      r.count = COUNT_W'(shadow_count);
      results_due.push_back(r);
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected 'h%08h, actual 'h%08h",
                  $time, name, want, got);
         error_count++;
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         if (req_tvalid && req_tready)
            predict_deque_op(req_held);
         if (!req_tvalid || req_tready) begin
            if (pending_ops.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
               req_held = pending_ops.pop_front();
               req_tdata  <= {{(REQ_DATA_W - OP_W - VALUE_W){1'b0}},
                              req_held.value, req_held.op};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result side pacing, with one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
         hold_done  <= 1'b0;
      end else if (hold_go && !hold_done) begin
         hold_left  <= RSP_HOLD_CYCLES;
         hold_done  <= 1'b1;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // result monitor
   always @(posedge clock) begin : rsp_monitor
      deque_rsp_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (results_due.size() == 0) begin
            $display("%0t ns: unexpected result, expected none, actual 'h%010h last %0b",
                     $time, rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            want = results_due.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_tdata[1:0]));
            check_field("found", 32'(want.found), 32'(rsp_tdata[2]));
            check_field("entry_count", 32'(want.count), 32'(rsp_tdata[7:3]));
            check_field("element", want.element, rsp_tdata[39:8]);
            check_field("last", 32'(want.last), 32'(rsp_tlast));
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic push_op(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value);
      deque_req_t req;
      req.op    = op;
      req.value = value;
      pending_ops.push_back(req);
   endtask

   task automatic wait_drained();
      do
         @(negedge clock);
      while (pending_ops.size() != 0 || req_tvalid || results_due.size() != 0);
   endtask

   // small pool gives duplicates and search hits; extremes and full words too
   task automatic queue_random(input int n);
      logic [OP_W-1:0]    op;
      logic [VALUE_W-1:0] value;
      int                 pick;
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(99);
         if (pick < 25)      op = OP_ADD_HEAD;
         else if (pick < 50) op = OP_ADD_TAIL;
         else if (pick < 60) op = OP_REMOVE_HEAD;
         else if (pick < 70) op = OP_REMOVE_TAIL;
         else if (pick < 81) op = OP_SEARCH;
         else if (pick < 87) op = OP_DEDUP;
         else if (pick < 96) op = OP_READ_OUT;
         else                op = OP_UNUSED;
         pick = $urandom_range(9);
         if (pick < 5)       value = $urandom_range(7) - 3;
         else if (pick == 5) value = 32'h8000_0000;
         else if (pick == 6) value = 32'h7fff_ffff;
         else                value = $urandom();
         push_op(op, value);
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      req_idle_pct = 21;
      rsp_idle_pct = 60;

      // empty store cases
      push_op(OP_REMOVE_HEAD, 32'h0);
      push_op(OP_REMOVE_TAIL, 32'h0);
      push_op(OP_SEARCH, 32'h0);
      push_op(OP_DEDUP, 32'h0);
      push_op(OP_READ_OUT, 32'h0);
      push_op(OP_UNUSED, 32'hffff_ffff);
      // extremes, head wrap and duplicates
      push_op(OP_ADD_HEAD, 32'h8000_0000);
      push_op(OP_ADD_TAIL, 32'h7fff_ffff);
      push_op(OP_ADD_HEAD, 32'hffff_ffff);
      push_op(OP_ADD_TAIL, 32'h0);
      push_op(OP_ADD_TAIL, 32'h7fff_ffff);
      push_op(OP_ADD_HEAD, 32'h8000_0000);
      push_op(OP_SEARCH, 32'h7fff_ffff);
      push_op(OP_SEARCH, 32'h0001_2345);
      push_op(OP_SEARCH, 32'h8000_0000);
      push_op(OP_READ_OUT, 32'h0);
      push_op(OP_DEDUP, 32'h0);
      push_op(OP_READ_OUT, 32'h0);
      push_op(OP_REMOVE_TAIL, 32'h0);
      push_op(OP_REMOVE_HEAD, 32'h0);
      push_op(OP_UNUSED, 32'haaaa_aaaa);
      push_op(OP_READ_OUT, 32'h0);
      push_op(OP_REMOVE_TAIL, 32'h0);
      push_op(OP_REMOVE_HEAD, 32'h0);
      push_op(OP_READ_OUT, 32'h0);
      wait_drained();

      // fill to full behind a long result hold-off
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_go      = 1'b1;
      for (int k = 0; k < DEPTH; k++)
         push_op(k[0] ? OP_ADD_HEAD : OP_ADD_TAIL, $urandom());
      push_op(OP_ADD_TAIL, 32'h5555_5555);
      push_op(OP_ADD_HEAD, 32'h5555_5555);
      push_op(OP_SEARCH, 32'h5555_5555);
      push_op(OP_READ_OUT, 32'h0);
      for (int k = 0; k < 6; k++)
         push_op(OP_REMOVE_TAIL, 32'h0);
      for (int k = 0; k < 6; k++)
         push_op(OP_ADD_TAIL, $urandom_range(1));
      push_op(OP_DEDUP, 32'h0);
      push_op(OP_READ_OUT, 32'h0);
      wait_drained();

      req_idle_pct = 21;
      rsp_idle_pct = 60;
      queue_random(50);
      wait_drained();

      req_idle_pct = 60;
      rsp_idle_pct = 21;
      queue_random(50);
      wait_drained();

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      queue_random(40);
      wait_drained();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (results_due.size() != 0) begin
         $display("%0t ns: results outstanding, expected 0, actual %0d",
                  $time, results_due.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
